/* sv/imu_sav_pkg.sv */
// Shared types and constants for the IMU sample average/validate block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package imu_sav_pkg;

    localparam int AXES         = 6;
    localparam int AXIS_W       = 16;
    localparam int WINDOW_DEPTH = 8;   // must be a power of two
    localparam int POS_W        = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = AXIS_W + POS_W;
    localparam int MAX_REPEATS  = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int TALLY_W      = 8;

    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 16'd32768;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT  = 3'd7;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_RANGE = 2'd1,
        FAULT_STUCK = 2'd2
    } t_fault;

    typedef logic [AXES-1:0][AXIS_W-1:0] t_axes;

    typedef struct packed {
        logic signed [AXIS_W-1:0] raw_accel_x;
        logic signed [AXIS_W-1:0] raw_accel_y;
        logic signed [AXIS_W-1:0] raw_accel_z;
        logic signed [AXIS_W-1:0] raw_gyro_x;
        logic signed [AXIS_W-1:0] raw_gyro_y;
        logic signed [AXIS_W-1:0] raw_gyro_z;
    } t_sample_in;

    typedef struct packed {
        logic signed [AXIS_W-1:0] avg_accel_x;
        logic signed [AXIS_W-1:0] avg_accel_y;
        logic signed [AXIS_W-1:0] avg_accel_z;
        logic signed [AXIS_W-1:0] avg_gyro_x;
        logic signed [AXIS_W-1:0] avg_gyro_y;
        logic signed [AXIS_W-1:0] avg_gyro_z;
        logic                     sample_valid;
        logic [1:0]               fault_cause;
        logic [TALLY_W-1:0]       error_tally;
    } t_result_out;

    typedef struct packed {
        t_axes             offset;
        logic [AXIS_W-1:0] accel_limit;
        logic [AXIS_W-1:0] gyro_limit;
    } t_cfg;

    typedef struct packed {
        logic               sample_valid;
        t_fault             fault_cause;
        logic [TALLY_W-1:0] error_tally;
    } t_check;

endpackage

/* sv/imu_sav_input.sv */
// Input register: captures a request and stores the offset-corrected sample.
// Depends on imu_sav_pkg.
`timescale 1ns / 1ps

module imu_sav_input
    import imu_sav_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_sample_in i_in_data,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    output logic       o_valid,
    output t_axes      o_sample
);

    logic  r_valid;
    logic  n_valid;
    t_axes r_sample;
    t_axes n_sample;
    t_axes raw;
    logic  accept;

    assign raw = {i_in_data.raw_accel_x, i_in_data.raw_accel_y, i_in_data.raw_accel_z,
                  i_in_data.raw_gyro_x, i_in_data.raw_gyro_y, i_in_data.raw_gyro_z};

    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    // wrapping 16-bit subtract per axis
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sample[a] = raw[a] - i_cfg.offset[a];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

/* sv/imu_sav_check.sv */
// Sample validation: range check, stuck-reading detection, saturating error tally.
// Depends on imu_sav_pkg.
`timescale 1ns / 1ps

module imu_sav_check
    import imu_sav_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  t_axes  i_sample,
    input  logic   i_primed,
    input  t_cfg   i_cfg,
    output t_check o_check
);

    localparam logic [TALLY_W-1:0] CNT_MAX   = '1;
    localparam logic [TALLY_W-1:0] REPEAT_TH = TALLY_W'(MAX_REPEATS);

    t_axes              r_last;
    logic [TALLY_W-1:0] r_repeat;
    logic [TALLY_W-1:0] n_repeat;
    logic [TALLY_W-1:0] r_faults;
    logic [TALLY_W-1:0] n_faults;
    logic               out_of_range;
    logic               same;
    t_fault             cause;
    logic [AXIS_W:0]    ext;
    logic [AXIS_W:0]    mag;
    logic [AXIS_W-1:0]  lim;

    // magnitude in 17 bits so that -32768 reads as 32768
    // accel axes sit in the top three lanes
    always_comb begin
        out_of_range = 1'b0;
        ext          = '0;
        mag          = '0;
        lim          = '0;
        for (int a = 0; a < AXES; a++) begin
            ext = {i_sample[a][AXIS_W-1], i_sample[a]};
            mag = ext[AXIS_W] ? (~ext + 1'b1) : ext;
            lim = (a >= 3) ? i_cfg.accel_limit : i_cfg.gyro_limit;
            if (mag > {1'b0, lim}) begin
                out_of_range = 1'b1;
            end
        end
    end

    assign same = (i_sample == r_last);

    always_comb begin
        n_repeat = r_repeat;
        cause    = FAULT_NONE;
        if (out_of_range) begin
            cause = FAULT_RANGE;
        end else if (i_primed) begin
            if (same) begin
                if (r_repeat != CNT_MAX) begin
                    n_repeat = r_repeat + 1'b1;
                end
                if (n_repeat > REPEAT_TH) begin
                    cause = FAULT_STUCK;
                end
            end else begin
                n_repeat = '0;
            end
        end
    end

    always_comb begin
        n_faults = r_faults;
        if (cause != FAULT_NONE) begin
            if (r_faults != CNT_MAX) begin
                n_faults = r_faults + 1'b1;
            end
        end else if (r_faults != '0) begin
            n_faults = r_faults - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat <= '0;
            r_faults <= '0;
        end else if (i_advance) begin
            r_repeat <= n_repeat;
            r_faults <= n_faults;
        end
    end

    // every sample enters the ring, so the last stored sample is the previous one
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_last <= i_sample;
        end
    end

    assign o_check.sample_valid = (cause == FAULT_NONE);
    assign o_check.fault_cause  = cause;
    assign o_check.error_tally  = n_faults;

endmodule

/* sv/imu_sav_window.sv */
// Moving-average window: sample ring, running per-axis sums, truncating average.
// Depends on imu_sav_pkg.
`timescale 1ns / 1ps

module imu_sav_window
    import imu_sav_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  t_axes i_sample,
    output logic  o_primed,
    output t_axes o_avg
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_DEPTH - 1);
    localparam logic [SUM_W-1:0] BIAS     = SUM_W'(WINDOW_DEPTH - 1);

    t_axes                          r_ring [WINDOW_DEPTH];
    logic [POS_W-1:0]               r_pos;
    logic                           r_primed;
    logic [AXES-1:0][SUM_W-1:0]     r_sums;
    logic [AXES-1:0][SUM_W-1:0]     n_sums;
    t_axes                          old;
    logic [SUM_W-1:0]               s_ext;
    logic [SUM_W-1:0]               o_ext;
    logic [SUM_W-1:0]               biased;

    assign old = r_ring[r_pos];

    always_comb begin
        s_ext  = '0;
        o_ext  = '0;
        biased = '0;
        for (int a = 0; a < AXES; a++) begin
            s_ext = SUM_W'($signed(i_sample[a]));
            o_ext = SUM_W'($signed(old[a]));
            if (r_primed) begin
                n_sums[a] = r_sums[a] + s_ext - o_ext;
                // round toward zero before the shift
                biased   = n_sums[a] + (n_sums[a][SUM_W-1] ? BIAS : '0);
                o_avg[a] = biased[POS_W +: AXIS_W];
            end else begin
                n_sums[a] = s_ext << POS_W;
                o_avg[a]  = i_sample[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_primed <= 1'b0;
            r_sums   <= '0;
        end else if (i_advance) begin
            r_primed <= 1'b1;
            r_sums   <= n_sums;
            if (r_primed) begin
                r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                if (!r_primed || (r_pos == POS_W'(k))) begin
                    r_ring[k] <= i_sample;
                end
            end
        end
    end

    assign o_primed = r_primed;

endmodule

/* sv/imu_sample_average_validate_core.sv */
// Top level of the IMU sample average/validate block: config registers,
// input and result registers. Depends on imu_sav_pkg and the imu_sav_* modules.
`timescale 1ns / 1ps

// One request carries a raw six-axis IMU sample. The block subtracts the
// per-axis offsets (wrapping to 16 bits), flags the sample out of range when
// any accel or gyro magnitude exceeds its limit, flags it stuck when it has
// repeated the previous sample more than MAX_REPEATS times, keeps a saturating
// 0..255 error tally, and returns the truncated-toward-zero average over the
// last WINDOW_DEPTH samples. The first sample after reset fills the whole
// window and comes back unchanged. Each sample goes from the input register
// (offset applied) through the check and window logic into the result
// register. A new request is taken every cycle unless the result side stalls;
// the running sums and the one-slot ring read per sample set that rate.
// The user must make configuration writes while the block is idle; unenforced.
module imu_sample_average_validate_core
    import imu_sav_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_sample_in            i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_result_out           o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_out_valid;
    t_result_out r_out;
    t_result_out n_out;
    logic        stage_valid;
    t_axes       stage_sample;
    logic        advance;
    logic        primed;
    t_axes       avg;
    t_check      check;

    // register file; offsets are stored with axis 0 in the top lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset      <= '0;
            r_cfg.accel_limit <= LIMIT_RESET;
            r_cfg.gyro_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACCEL_OFF_X: r_cfg.offset[5] <= i_cfg_data;
                REG_ACCEL_OFF_Y: r_cfg.offset[4] <= i_cfg_data;
                REG_ACCEL_OFF_Z: r_cfg.offset[3] <= i_cfg_data;
                REG_GYRO_OFF_X:  r_cfg.offset[2] <= i_cfg_data;
                REG_GYRO_OFF_Y:  r_cfg.offset[1] <= i_cfg_data;
                REG_GYRO_OFF_Z:  r_cfg.offset[0] <= i_cfg_data;
                REG_ACCEL_LIMIT: r_cfg.accel_limit <= i_cfg_data;
                REG_GYRO_LIMIT:  r_cfg.gyro_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the stored sample moves on whenever the result register is free or draining
    assign advance = stage_valid && (!r_out_valid || !i_out_stall);

    imu_sav_input u_input (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_sample   (stage_sample)
    );

    imu_sav_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_sample (stage_sample),
        .i_primed (primed),
        .i_cfg    (r_cfg),
        .o_check  (check)
    );

    imu_sav_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_sample (stage_sample),
        .o_primed (primed),
        .o_avg    (avg)
    );

    always_comb begin
        n_out.avg_accel_x  = avg[5];
        n_out.avg_accel_y  = avg[4];
        n_out.avg_accel_z  = avg[3];
        n_out.avg_gyro_x   = avg[2];
        n_out.avg_gyro_y   = avg[1];
        n_out.avg_gyro_z   = avg[0];
        n_out.sample_valid = check.sample_valid;
        n_out.fault_cause  = check.fault_cause;
        n_out.error_tally  = check.error_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* sv/imu_sav_checker.sv */
// Port-level checker for imu_sample_average_validate_core, bound to the top level.
// Depends on imu_sav_pkg.
`timescale 1ns / 1ps

module imu_sav_checker
    import imu_sav_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_result_out o_out_data
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_valid_vs_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample_valid == (o_out_data.fault_cause == FAULT_NONE)))
        else $error("sample_valid disagrees with fault_cause");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty result register");

endmodule

bind imu_sample_average_validate_core imu_sav_checker u_sav_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
